>>> hdl/suba_pkg.sv
// Package for the slot usage bitmap allocator: sizes, kind codes, controller types.
// No dependencies; used by the top level, the controller and the datapath.
`default_nettype none
package suba_pkg;
  localparam int MaxSlots  = 1024;
  localparam int WordBits  = 32;
  localparam int NumWords  = MaxSlots / WordBits;
  localparam int IdxW      = $clog2(MaxSlots);
  localparam int SizeW     = IdxW + 1;
  localparam int WordIdxW  = $clog2(NumWords);
  localparam int BitIdxW   = $clog2(WordBits);

  typedef enum logic [2:0] {
    KIND_START   = 3'd0,
    KIND_MARK    = 3'd1,
    KIND_ALLOC   = 3'd2,
    KIND_QUERY   = 3'd3,
    KIND_COMPACT = 3'd4
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic clr_start;  // begin clear sweep
    logic scan_start; // begin word scan
    logic apply;      // perform the kind's update
    logic last_start; // begin last-used scan
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic apply_done;
    logic last_done;
  } sts_t;
endpackage
`default_nettype wire

>>> hdl/slot_usage_bitmap_allocator_unit.sv
// Slot usage bitmap allocator: a 1024-slot used/free bitmap with allocate and
// compact. Channels: s_axis (kind, slot_index, slot_count) in, m_axis result out.
// One beat in, one beat out. Work per beat runs over the 32-word bitmap memory:
//   start:  clear sweep of every word, then a last-used scan.
//   others: scan of every word, the kind's update, then a last-used scan.
// The bitmap memory is read one word per cycle.
// Only one beat is in work at a time; s_axis_tready is high while idle.
// The result is held on m_axis until taken; stalls only delay the next beat.
// Reset empties the table (size 0); a flag per memory word marks it written,
// so words untouched since reset read as zero and no clearing pass runs.
// Depends on suba_pkg, suba_ctrl and suba_dp.
`default_nettype none
module slot_usage_bitmap_allocator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // kind[2:0], slot_index[12:3], slot_count[22:13]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata   // ok[0], slot_a[10:1], slot_b[20:11],
                                          // slot_used[21], table_size[32:22], last_used[42:33]
);
  suba_pkg::cmd_t cmd;
  suba_pkg::sts_t sts;
  logic                            ok, su;
  logic [suba_pkg::IdxW-1:0]       a, b, lu;
  logic [suba_pkg::SizeW-1:0]      sz;

  suba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .kind_i     (s_axis_tdata[2:0]),
    .cmd_o      (cmd), .sts_i(sts)
  );

  suba_dp u_dp (
    .clk_i, .rst_ni,
    .kind_i       (s_axis_tdata[2:0]),
    .slot_index_i (s_axis_tdata[12:3]),
    .slot_count_i (s_axis_tdata[22:13]),
    .cmd_i        (cmd), .sts_o(sts),
    .ok_o(ok), .slot_a_o(a), .slot_b_o(b), .slot_used_o(su),
    .table_size_o(sz), .last_used_o(lu)
  );

  assign m_axis_tdata = {5'd0, lu, sz, su, b, a, ok};
endmodule
`default_nettype wire

>>> hdl/suba_ctrl.sv
// Controller for the slot usage bitmap allocator: sequences each beat's work.
// Depends on suba_pkg.
`default_nettype none
module suba_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire logic [2:0]       kind_i,
  output suba_pkg::cmd_t        cmd_o,
  input  wire suba_pkg::sts_t   sts_i
);
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLR   = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_APPLY = 7'b0001000,
    ST_LAST  = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_WAIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (kind_i == suba_pkg::KIND_START) begin
            cmd_o.clr_start = 1'b1;
            state_d = ST_CLR;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_CLR: if (sts_i.clr_done) begin
        cmd_o.last_start = 1'b1;
        state_d = ST_LAST;
      end
      ST_SCAN: if (sts_i.scan_done) begin
        cmd_o.apply = 1'b1;
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        // drop apply once the update has finished
        if (sts_i.apply_done) begin
          cmd_o.last_start = 1'b1;
          state_d = ST_LAST;
        end else begin
          cmd_o.apply = 1'b1;
        end
      end
      ST_LAST: if (sts_i.last_done) state_d = ST_OUT;
      ST_OUT: state_d = out_ready_i ? ST_IDLE : ST_WAIT;
      ST_WAIT: if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT) || (state_q == ST_WAIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end
endmodule
`default_nettype wire

>>> hdl/suba_dp.sv
// Datapath for the slot usage bitmap allocator: bitmap memory, word scans, result.
// Depends on suba_pkg.
`default_nettype none
module suba_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [2:0]                    kind_i,
  input  wire logic [suba_pkg::IdxW-1:0]     slot_index_i,
  input  wire logic [suba_pkg::IdxW-1:0]     slot_count_i,
  input  wire suba_pkg::cmd_t                cmd_i,
  output suba_pkg::sts_t                     sts_o,
  output logic                               ok_o,
  output logic [suba_pkg::IdxW-1:0]          slot_a_o,
  output logic [suba_pkg::IdxW-1:0]          slot_b_o,
  output logic                               slot_used_o,
  output logic [suba_pkg::SizeW-1:0]         table_size_o,
  output logic [suba_pkg::IdxW-1:0]          last_used_o
);
  localparam int W  = suba_pkg::WordBits;
  localparam int IW = suba_pkg::IdxW;
  localparam int SW = suba_pkg::SizeW;
  localparam int WI = suba_pkg::WordIdxW;
  localparam int BI = suba_pkg::BitIdxW;
  localparam int NW = suba_pkg::NumWords;
  localparam logic [SW-1:0] MaxSize = SW'(suba_pkg::MaxSlots);

  // Bitmap memory, one word per row; one write and one read port, registered read
  logic [W-1:0]  mem [NW];
  logic          we;
  logic [WI-1:0] waddr, raddr;
  logic [W-1:0]  wdata, rdata_q;
  logic [NW-1:0] wvld_q;         // word written since reset
  logic          vld_q;          // rdata_q comes from a written word

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
    vld_q   <= wvld_q[raddr];
  end

  // Captured beat and scan state
  logic [2:0]    kind_q;
  logic [IW-1:0] idx_q, cnt_q;
  logic [SW-1:0] size_q;
  logic          clr_q;          // clear sweep running
  logic [WI:0]   clr_ptr_q;
  logic          scan_q, last_q;
  logic [WI:0]   ptr_q;          // address issued
  logic          pend_q;         // read data valid for rd_w_q
  logic [WI-1:0] rd_w_q;
  logic          ff_hit_q, hu_hit_q, lu_hit_q;
  logic [IW-1:0] ff_q, hu_q, lu_q;
  logic [1:0]    ap_q;           // apply step
  logic          ok_q, su_q;
  logic [IW-1:0] a_q, b_q;

  // Mask of bits of word w inside size, leaving out slot 0 when lo1 is set
  function automatic logic [W-1:0] range_mask(input logic [WI-1:0] w,
                                              input logic [SW-1:0] sz,
                                              input logic lo1);
    logic [W-1:0]  m;
    logic [SW-1:0] base;
    base = SW'(w) << BI;
    for (int k = 0; k < W; k++)
      m[k] = ((base + SW'(k)) < sz) && !(lo1 && w == '0 && k == 0);
    return m;
  endfunction

  function automatic logic [BI-1:0] lowest(input logic [W-1:0] v);
    logic [BI-1:0] r;
    r = '0;
    for (int k = W - 1; k >= 0; k--) if (v[k]) r = BI'(k);
    return r;
  endfunction

  function automatic logic [BI-1:0] highest(input logic [W-1:0] v);
    logic [BI-1:0] r;
    r = '0;
    for (int k = 0; k < W; k++) if (v[k]) r = BI'(k);
    return r;
  endfunction

  logic [W-1:0] word_r, used_m, used1_m, free_m;
  assign word_r  = vld_q ? rdata_q : '0;
  assign used_m  = word_r & range_mask(rd_w_q, size_q, 1'b0);
  assign used1_m = word_r & range_mask(rd_w_q, size_q, 1'b1);
  assign free_m  = ~word_r & range_mask(rd_w_q, size_q, 1'b1);

  logic [IW-1:0] tgt;            // slot touched by a single-bit update
  logic [WI-1:0] tw;
  logic          sbit;
  logic          do_write;

  always_comb begin
    we = 1'b0; waddr = '0; wdata = rdata_q; raddr = ptr_q[WI-1:0];
    tgt = idx_q; sbit = 1'b1; do_write = 1'b0;
    if (clr_q) begin
      we = 1'b1; waddr = clr_ptr_q[WI-1:0]; wdata = '0;
    end
    case (kind_q)
      suba_pkg::KIND_MARK: begin
        tgt = idx_q; do_write = SW'(idx_q) < size_q;
      end
      suba_pkg::KIND_ALLOC: begin
        tgt = ff_hit_q ? ff_q : size_q[IW-1:0];
        do_write = ff_hit_q || size_q < MaxSize;
      end
      suba_pkg::KIND_COMPACT: begin
        do_write = hu_hit_q && ff_hit_q && ff_q < hu_q;
        tgt  = (ap_q >= 2'd2) ? ff_q : hu_q;
        sbit = (ap_q >= 2'd2);
      end
      default: ;
    endcase
    tw = tgt[IW-1:BI];
    // fetch the target word in the cycle before its write
    if ((ap_q != 2'd0 || cmd_i.apply) && !clr_q) raddr = tw;
    if ((ap_q == 2'd1 || ap_q == 2'd3) && do_write) begin
      we = 1'b1; waddr = tw;
      wdata = word_r;
      wdata[tgt[BI-1:0]] = sbit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0; clr_q <= 1'b0; clr_ptr_q <= '0; scan_q <= 1'b0;
      last_q <= 1'b0; ptr_q <= '0; pend_q <= 1'b0; ap_q <= '0;
      wvld_q <= '0; sts_o <= '0;
    end else begin
      sts_o <= '0;
      if (we) wvld_q[waddr] <= 1'b1;
      if (cmd_i.clr_start) begin
        clr_q <= 1'b1; clr_ptr_q <= '0;
      end else if (clr_q) begin
        clr_ptr_q <= clr_ptr_q + 1'b1;
        if (clr_ptr_q[WI-1:0] == WI'(NW - 1)) begin
          clr_q <= 1'b0; sts_o.clr_done <= 1'b1;
          if (SW'(cnt_q) + 1'b1 > MaxSize) size_q <= MaxSize;
          else size_q <= SW'(cnt_q) + 1'b1;
        end
      end
      if (cmd_i.scan_start || cmd_i.last_start) begin
        scan_q <= cmd_i.scan_start; last_q <= cmd_i.last_start;
        ptr_q <= '0; pend_q <= 1'b0;
      end else if (scan_q || last_q) begin
        if (ptr_q != (WI + 1)'(NW)) ptr_q <= ptr_q + 1'b1;
        pend_q <= ptr_q != (WI + 1)'(NW);
        if (pend_q && rd_w_q == WI'(NW - 1)) begin
          scan_q <= 1'b0; last_q <= 1'b0;
          sts_o.scan_done <= scan_q; sts_o.last_done <= last_q;
        end
      end
      if (cmd_i.apply) begin
        ap_q <= ap_q + 1'b1;
        if ((ap_q == 2'd1 && kind_q != suba_pkg::KIND_COMPACT) || ap_q == 2'd3) begin
          ap_q <= '0; sts_o.apply_done <= 1'b1;
          if (kind_q == suba_pkg::KIND_ALLOC && !ff_hit_q && size_q < MaxSize)
            size_q <= size_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_w_q <= raddr;
    if (cmd_i.load) begin
      kind_q <= kind_i; idx_q <= slot_index_i; cnt_q <= slot_count_i;
      ok_q <= 1'b0; su_q <= 1'b0; a_q <= '0; b_q <= '0;
    end
    if (cmd_i.scan_start) begin
      ff_hit_q <= 1'b0; hu_hit_q <= 1'b0;
    end
    if (cmd_i.last_start) lu_hit_q <= 1'b0;
    if (scan_q && pend_q) begin
      if (!ff_hit_q && free_m != '0) begin
        ff_hit_q <= 1'b1; ff_q <= {rd_w_q, lowest(free_m)};
      end
      if (used1_m != '0) begin
        hu_hit_q <= 1'b1; hu_q <= {rd_w_q, highest(used1_m)};
      end
      if (kind_q == suba_pkg::KIND_QUERY && rd_w_q == idx_q[IW-1:BI])
        su_q <= used_m[idx_q[BI-1:0]];
    end
    if (last_q && pend_q && used_m != '0) begin
      lu_hit_q <= 1'b1; lu_q <= {rd_w_q, highest(used_m)};
    end
    if (cmd_i.clr_start && cmd_i.load) ok_q <= SW'(slot_count_i) + 1'b1 <= MaxSize;
    if (cmd_i.apply && ap_q == 2'd1) begin
      ok_q <= do_write;
      if (do_write && kind_q != suba_pkg::KIND_MARK) begin
        a_q <= (kind_q == suba_pkg::KIND_COMPACT) ? ff_q : tgt;
        if (kind_q == suba_pkg::KIND_COMPACT) b_q <= hu_q;
      end
    end
  end

  assign ok_o         = ok_q;
  assign slot_a_o     = a_q;
  assign slot_b_o     = b_q;
  assign slot_used_o  = su_q;
  assign table_size_o = size_q;
  assign last_used_o  = lu_hit_q ? lu_q : '0;
endmodule
`default_nettype wire

>>> hdl/suba_checker.sv
// Port checker for the slot usage bitmap allocator, bound to the top level.
// Depends on slot_usage_bitmap_allocator_unit.
`default_nettype none
module suba_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while result pending");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken during work");
  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[32:22] <= 11'd1024)
    else $error("table size beyond capacity");
endmodule

bind slot_usage_bitmap_allocator_unit suba_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for slot_usage_bitmap_allocator_unit: streams kind/slot beats,
// predicts each result from its own bitmap model and compares every output beat.
// Depends on suba_pkg and the block's RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0] kind;
    logic [9:0] slot_index;
    logic [9:0] slot_count;
    bit         hold;  // wait for every expected result before sending
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [9:0]  slot_a;
    logic [9:0]  slot_b;
    logic        slot_used;
    logic [10:0] table_size;
    logic [9:0]  last_used;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  slot_usage_bitmap_allocator_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #2 clk_i = ~clk_i;

  req_t pending_q[$];
  rsp_t expected_q[$];
  bit   used_map[suba_pkg::MaxSlots];
  int   table_len = 0;
  int   beats_in = 0;
  int   errors = 0;
  req_t cur;

  function automatic int lowest_free();
    for (int i = 1; i < table_len && i < suba_pkg::MaxSlots; i++)
      if (!used_map[i]) return i;
    return -1;
  endfunction

  // Apply one beat to the shadow bitmap and return the result it must produce.
  function automatic rsp_t apply_beat(req_t r);
    rsp_t o;
    int f;
    int hi;
    o = '0;
    case (r.kind)
      suba_pkg::KIND_START: begin
        foreach (used_map[i]) used_map[i] = 1'b0;
        if (int'(r.slot_count) + 1 > suba_pkg::MaxSlots) table_len = suba_pkg::MaxSlots;
        else begin
          table_len = int'(r.slot_count) + 1;
          o.ok = 1'b1;
        end
      end
      suba_pkg::KIND_MARK: begin
        if (int'(r.slot_index) < table_len) begin
          used_map[r.slot_index] = 1'b1;
          o.ok = 1'b1;
        end
      end
      suba_pkg::KIND_ALLOC: begin
        f = lowest_free();
        if (f > 0) begin
          used_map[f] = 1'b1;
          o.slot_a = 10'(f);
          o.ok = 1'b1;
        end else if (table_len < suba_pkg::MaxSlots) begin
          used_map[table_len] = 1'b1;
          o.slot_a = 10'(table_len);
          table_len++;
          o.ok = 1'b1;
        end
      end
      suba_pkg::KIND_QUERY: begin
        o.slot_used = int'(r.slot_index) < table_len && used_map[r.slot_index];
      end
      suba_pkg::KIND_COMPACT: begin
        hi = 0;
        for (int i = table_len - 1; i >= 1; i--) if (used_map[i]) begin
          hi = i;
          break;
        end
        f = lowest_free();
        if (hi >= 1 && f > 0 && f < hi) begin
          used_map[hi] = 1'b0;
          used_map[f] = 1'b1;
          o.slot_a = 10'(f);
          o.slot_b = 10'(hi);
          o.ok = 1'b1;
        end
      end
      default: ;
    endcase
    o.table_size = 11'(table_len);
    for (int i = table_len - 1; i >= 0; i--) if (used_map[i]) begin
      o.last_used = 10'(i);
      break;
    end
    return o;
  endfunction

  function automatic bit quiet_stretch();
    return beats_in >= 300 && beats_in < 450;
  endfunction

  // Driver: advance to the next queued beat once the current one is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(apply_beat(cur));
        beats_in <= beats_in + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 && !(pending_q[0].hold && (expected_q.size() > 0 ||
            (s_axis_tvalid && s_axis_tready))) &&
            (quiet_stretch() || $urandom_range(99) >= 30)) begin
          cur = pending_q.pop_front();
          s_axis_tdata <= {1'b0, cur.slot_count, cur.slot_index, cur.kind};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output beat against the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t e;
    rsp_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.ok = m_axis_tdata[0];
        got.slot_a = m_axis_tdata[10:1];
        got.slot_b = m_axis_tdata[20:11];
        got.slot_used = m_axis_tdata[21];
        got.table_size = m_axis_tdata[32:22];
        got.last_used = m_axis_tdata[42:33];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (got !== e) begin
            $display("%0t: mismatch expected ok=%b a=%0d b=%0d used=%b size=%0d last=%0d",
                     $realtime, e.ok, e.slot_a, e.slot_b, e.slot_used, e.table_size,
                     e.last_used);
            $display("%0t:          actual ok=%b a=%0d b=%0d used=%b size=%0d last=%0d",
                     $realtime, got.ok, got.slot_a, got.slot_b, got.slot_used,
                     got.table_size, got.last_used);
            errors++;
          end
        end
      end
      m_axis_tready <= quiet_stretch() || $urandom_range(99) >= 30;
    end
  end

  function automatic req_t mk(logic [2:0] k, int idx, int cnt, bit hold = 1'b0);
    req_t r;
    r.kind = k;
    r.slot_index = 10'(idx);
    r.slot_count = 10'(cnt);
    r.hold = hold;
    return r;
  endfunction

  initial begin
    int k;
    int cnt;
    int sz;

    // directed: empty table, bounds, every kind, compaction cases
    pending_q.push_back(mk(suba_pkg::KIND_ALLOC, 0, 0));
    pending_q.push_back(mk(suba_pkg::KIND_QUERY, 0, 0));
    pending_q.push_back(mk(suba_pkg::KIND_ALLOC, 0, 0));
    pending_q.push_back(mk(suba_pkg::KIND_QUERY, 1, 0));
    pending_q.push_back(mk(suba_pkg::KIND_START, 1023, 1023));
    pending_q.push_back(mk(suba_pkg::KIND_MARK, 1023, 0));
    pending_q.push_back(mk(suba_pkg::KIND_QUERY, 1023, 1023));
    pending_q.push_back(mk(suba_pkg::KIND_COMPACT, 0, 0));
    pending_q.push_back(mk(suba_pkg::KIND_START, 0, 0));
    pending_q.push_back(mk(suba_pkg::KIND_MARK, 1, 0));
    pending_q.push_back(mk(suba_pkg::KIND_MARK, 0, 0));
    pending_q.push_back(mk(suba_pkg::KIND_QUERY, 1023, 0));
    pending_q.push_back(mk(suba_pkg::KIND_ALLOC, 0, 0));
    pending_q.push_back(mk(suba_pkg::KIND_START, 0, 5));
    pending_q.push_back(mk(suba_pkg::KIND_MARK, 5, 0));
    pending_q.push_back(mk(suba_pkg::KIND_MARK, 6, 0));
    pending_q.push_back(mk(suba_pkg::KIND_COMPACT, 0, 0));
    pending_q.push_back(mk(suba_pkg::KIND_QUERY, 1, 0));
    pending_q.push_back(mk(suba_pkg::KIND_COMPACT, 0, 0));
    for (int i = 0; i < 4; i++) pending_q.push_back(mk(suba_pkg::KIND_ALLOC, 0, 0));
    pending_q.push_back(mk(3'd5, 1023, 1023));
    pending_q.push_back(mk(3'd7, 0, 0, 1'b1));
    pending_q.push_back(mk(3'd6, 512, 512));

    // random: a start, then a run of mostly in-range work on that table
    while (pending_q.size() < 780) begin
      cnt = ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(40);
      pending_q.push_back(mk(suba_pkg::KIND_START, $urandom_range(1023), cnt));
      sz = cnt + 1;
      repeat ($urandom_range(60, 10)) begin
        k = $urandom_range(99);
        if (k < 25) pending_q.push_back(mk(suba_pkg::KIND_MARK,
            ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(sz + 2), 0));
        else if (k < 50) pending_q.push_back(mk(suba_pkg::KIND_ALLOC, $urandom_range(1023),
            $urandom_range(1023)));
        else if (k < 70) pending_q.push_back(mk(suba_pkg::KIND_QUERY,
            ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(sz + 2), 0));
        else if (k < 95) pending_q.push_back(mk(suba_pkg::KIND_COMPACT,
            $urandom_range(1023), 0));
        else pending_q.push_back(mk(3'($urandom_range(7, 5)), $urandom_range(1023),
            $urandom_range(1023)));
        if (k < 50) sz++;
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !s_axis_tvalid && expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
hdl/suba_pkg.sv
hdl/suba_ctrl.sv
hdl/suba_dp.sv
hdl/slot_usage_bitmap_allocator_unit.sv
hdl/suba_checker.sv
tb/tb_top.sv
